>>> rtl/lrip_pkg.sv
`default_nettype none
package lrip_pkg;
  localparam int NumRingsDef = 32;
  localparam int PointsPerRingDef = 1812;
  localparam int CordicSteps = 16;
  localparam int AngW = 34;
  localparam int CordW = 40;
  localparam int SqW = 37;
  localparam int RootW = 19;

  localparam logic [0:0] CfgFovUpper = 1'b0;
  localparam logic [0:0] CfgFovLower = 1'b1;

  localparam logic signed [AngW-1:0] Ang90 = AngW'(90 * 65536);
  localparam logic signed [AngW-1:0] Ang180 = AngW'(180 * 65536);

  function automatic logic signed [AngW-1:0] atan_q16(input logic [3:0] i);
    logic signed [AngW-1:0] v;
    begin
      case (i)
        4'd0: v = AngW'(2949120);
        4'd1: v = AngW'(1740967);
        4'd2: v = AngW'(919879);
        4'd3: v = AngW'(466945);
        4'd4: v = AngW'(234379);
        4'd5: v = AngW'(117304);
        4'd6: v = AngW'(58666);
        4'd7: v = AngW'(29335);
        4'd8: v = AngW'(14668);
        4'd9: v = AngW'(7334);
        4'd10: v = AngW'(3667);
        4'd11: v = AngW'(1833);
        4'd12: v = AngW'(917);
        4'd13: v = AngW'(458);
        4'd14: v = AngW'(229);
        default: v = AngW'(115);
      endcase
      return v;
    end
  endfunction

  typedef struct packed {
    logic signed [CordW-1:0] a;
    logic signed [CordW-1:0] b;
    logic signed [AngW-1:0] ang;
    logic done;
  } cord_t;

  function automatic cord_t cord_init(input logic signed [CordW-1:0] a0,
                                      input logic signed [CordW-1:0] b0);
    cord_t c;
    logic signed [CordW-1:0] a;
    logic signed [CordW-1:0] b;
    begin
      a = a0 <<< 12;
      b = b0 <<< 12;
      c.ang = '0;
      c.done = 1'b0;
      if (a0 == 0 && b0 == 0) begin
        c.done = 1'b1;
      end else if (b0 == 0 && a0 < 0) begin
        c.done = 1'b1;
        c.ang = -Ang180;
      end else if (a < 0) begin
        if (b >= 0) begin
          c.a = b; c.b = -a; c.ang = Ang90;
        end else begin
          c.a = -b; c.b = a; c.ang = -Ang90;
        end
      end
      if (!(a < 0) || c.done) begin
        c.a = a; c.b = b;
      end
      return c;
    end
  endfunction

  function automatic cord_t cord_step(input cord_t c, input logic [3:0] i);
    cord_t r;
    logic signed [CordW-1:0] da;
    logic signed [CordW-1:0] db;
    begin
      r = c;
      da = c.b >>> i;
      db = c.a >>> i;
      if (!c.done) begin
        if (c.b >= 0) begin
          r.a = c.a + da; r.b = c.b - db; r.ang = c.ang + atan_q16(i);
        end else begin
          r.a = c.a - da; r.b = c.b + db; r.ang = c.ang - atan_q16(i);
        end
      end
      return r;
    end
  endfunction
endpackage
`default_nettype wire

>>> rtl/lidar_range_image_projection.sv
// Lidar range-image projection.
// s_axis carries one point per item: tdata = raw_x[17:0], raw_y[35:18],
// raw_z[53:36], zero padded to 56 bits. m_axis returns one item per point:
// tdata = ring_row[4:0], azimuth_col[15:5], depth[33:16], cell_valid[34],
// zero padded to 40 bits. The cfg channel writes fov_upper_deg (index 0)
// and fov_lower_deg (index 1); write only while the pipeline is empty.
// The datapath is a fully pipelined chain: one negate stage, one square
// stage, 19 square-root stages (one result bit each), then two 16-step
// CORDIC chains (one setup stage, two steps per stage after it), then two
// stages of products and range checks, a restoring row divider of one stage
// per row-index bit, and the output register. Throughput is one item per
// cycle while the output is not held. When m_axis_tready is low and an
// item waits at the output, the whole pipeline holds; s_axis_tready is
// high whenever the output register is empty or being taken, so no item
// is lost or repeated. Reset empties the pipeline and loads the field of
// view 15 / -25 degrees.
`default_nettype none
module lidar_range_image_projection
  import lrip_pkg::*;
#(
  parameter int NUM_RINGS = NumRingsDef,
  parameter int POINTS_PER_RING = PointsPerRingDef
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [55:0] s_axis_tdata,  // raw_x, raw_y, raw_z
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,  // ring_row, azimuth_col, depth, cell_valid
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);
  localparam int SqSt = RootW;
  localparam int CoSt = CordicSteps / 2;
  localparam int RowW = $clog2(NUM_RINGS);
  localparam int ColW = $clog2(POINTS_PER_RING);
  localparam int DivW = RowW + 9;
  localparam int NSt = 2 + SqSt + 1 + CoSt + 3 + RowW;
  localparam logic [18:0] ColRecip = 19'(((1 << 24) + 44) / 45);
  localparam logic signed [47:0] ColLim = 48'(POINTS_PER_RING * 45);

  logic signed [7:0] fov_upper;
  logic signed [7:0] fov_lower;
  logic              adv;
  logic [NSt-1:0]    vld;

  assign cfg_ready = 1'b1;
  assign adv = !vld[NSt-1] || m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      fov_upper <= 8'sd15;
      fov_lower <= -8'sd25;
    end else if (cfg_valid) begin
      case (cfg_index)
        CfgFovUpper: fov_upper <= cfg_data;
        CfgFovLower: fov_lower <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSt-2:0], s_axis_tvalid};
    end
  end

  // stage 0: negate and square
  logic signed [18:0] x0, y0, z0;
  always_ff @(posedge clk) begin
    if (adv) begin
      x0 <= 19'(signed'(s_axis_tdata[17:0]));
      y0 <= -19'(signed'(s_axis_tdata[35:18]));
      z0 <= -19'(signed'(s_axis_tdata[53:36]));
    end
  end
  logic [SqW-1:0] xx, yy;
  always_comb begin
    xx = SqW'(unsigned'(38'(x0) * 38'(x0)));
    yy = SqW'(unsigned'(38'(y0) * 38'(y0)));
  end

  // sqrt stages: one root bit per stage
  logic [SqW:0]        rem [SqSt+1];
  logic [RootW-1:0]    rt [SqSt+1];
  logic signed [18:0]  sx [SqSt+1], sy [SqSt+1], sz [SqSt+1];
  always_ff @(posedge clk) begin
    if (adv) begin
      rem[0] <= (SqW+1)'(xx) + (SqW+1)'(yy);
      rt[0] <= '0;
      sx[0] <= x0; sy[0] <= y0; sz[0] <= z0;
    end
  end
  for (genvar k = 0; k < SqSt; k++) begin : g_sq
    localparam int B = RootW - 1 - k;
    logic [SqW+1:0] trial;
    logic [RootW-1:0] cand;
    always_comb begin
      cand = rt[k] | (RootW'(1) << B);
      trial = (SqW+2)'(cand) * (SqW+2)'(cand);
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rem[k+1] <= rem[k];
        rt[k+1] <= (trial <= (SqW+2)'(rem[k])) ? cand : rt[k];
        sx[k+1] <= sx[k]; sy[k+1] <= sy[k]; sz[k+1] <= sz[k];
      end
    end
  end

  // CORDIC: init then two steps per stage
  cord_t ce [CoSt+1];
  cord_t ca [CoSt+1];
  logic [RootW-1:0] dep [CoSt+1];
  always_ff @(posedge clk) begin
    if (adv) begin
      ce[0] <= cord_init(CordW'(signed'({1'b0, rt[SqSt]})), CordW'(sz[SqSt]));
      ca[0] <= cord_init(CordW'(sx[SqSt]), CordW'(sy[SqSt]));
      dep[0] <= rt[SqSt];
    end
  end
  for (genvar k = 0; k < CoSt; k++) begin : g_co
    always_ff @(posedge clk) begin
      if (adv) begin
        ce[k+1] <= cord_step(cord_step(ce[k], 4'(2*k)), 4'(2*k+1));
        ca[k+1] <= cord_step(cord_step(ca[k], 4'(2*k)), 4'(2*k+1));
        dep[k+1] <= dep[k];
      end
    end
  end

  // cell stage 1: numerators and field-of-view span
  logic signed [47:0] rnum1, cnum1;
  logic [8:0]         rdiff1;
  logic               fov_ok1;
  logic [RootW-1:0]   dep1;
  always_ff @(posedge clk) begin
    if (adv) begin
      rnum1 <= ((48'(fov_upper) <<< 16) - 48'(ce[CoSt].ang)) * 48'(NUM_RINGS - 1);
      cnum1 <= (48'(ca[CoSt].ang) + 48'(Ang180)) * 48'(POINTS_PER_RING);
      rdiff1 <= 9'(10'(fov_upper) - 10'(fov_lower));
      fov_ok1 <= fov_upper > fov_lower;
      dep1 <= dep[CoSt];
    end
  end

  // cell stage 2: range checks, column by reciprocal of 45 after a 19-bit shift
  logic signed [47:0] rden_c, rlim_c, ct_c;
  logic               row_in_c, col_in_c;
  logic [DivW-1:0]    rn_c;
  logic [17:0]        tq_c;
  logic [36:0]        cprod_c;
  always_comb begin
    rden_c = $signed({23'b0, rdiff1, 16'b0});
    rlim_c = 48'(NUM_RINGS) * $signed({39'b0, rdiff1});
    row_in_c = (rnum1 < 0) ? (-rnum1 < rden_c) : ((rnum1 >>> 16) < rlim_c);
    rn_c = (rnum1 < 0) ? '0 : DivW'(rnum1 >>> 16);
    ct_c = cnum1 >>> 19;
    col_in_c = (cnum1 >= 0) && (ct_c < ColLim);
    tq_c = col_in_c ? 18'(ct_c) : '0;
    cprod_c = 37'(tq_c) * 37'(ColRecip);
  end

  logic [DivW-1:0]  rrem [RowW+1];
  logic [RowW-1:0]  rqt [RowW+1];
  logic [8:0]       rdv [RowW+1];
  logic             okd [RowW+1];
  logic [ColW-1:0]  cqd [RowW+1];
  logic [17:0]      depd [RowW+1];
  always_ff @(posedge clk) begin
    if (adv) begin
      rrem[0] <= rn_c;
      rqt[0] <= '0;
      rdv[0] <= rdiff1;
      okd[0] <= fov_ok1 && row_in_c && col_in_c;
      cqd[0] <= ColW'(cprod_c >> 24);
      depd[0] <= dep1[17:0];
    end
  end

  // row divider: one quotient bit per stage
  for (genvar k = 0; k < RowW; k++) begin : g_div
    localparam int B = RowW - 1 - k;
    logic [DivW-1:0] sub;
    logic            ge;
    always_comb begin
      sub = DivW'(rdv[k]) << B;
      ge = rrem[k] >= sub;
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rrem[k+1] <= ge ? rrem[k] - sub : rrem[k];
        rqt[k+1] <= ge ? (rqt[k] | (RowW'(1) << B)) : rqt[k];
        rdv[k+1] <= rdv[k];
        okd[k+1] <= okd[k];
        cqd[k+1] <= cqd[k];
        depd[k+1] <= depd[k];
      end
    end
  end

  // output register
  logic [4:0]         row_o;
  logic [10:0]        col_o;
  logic [17:0]        dep_o;
  logic               val_o;
  always_ff @(posedge clk) begin
    if (adv) begin
      val_o <= okd[RowW];
      row_o <= okd[RowW] ? 5'(rqt[RowW]) : '0;
      col_o <= okd[RowW] ? 11'(ColW'(POINTS_PER_RING - 1) - cqd[RowW]) : '0;
      dep_o <= depd[RowW];
    end
  end

  assign m_axis_tvalid = vld[NSt-1];
  assign m_axis_tdata = {5'b0, val_o, dep_o, col_o, row_o};
endmodule
`default_nettype wire
